// ----- design/mbe_pkg.sv -----
// shared types and constants of the mandelbrot escape-time pixel block
package mbe_pkg;

  // width of one operand slice of the shared multiplier
  localparam int OPER_W = 24;
  // accumulator width: holds the full 45x45-bit magnitude product
  localparam int ACC_W = 90;
  // default image width and height in pixels
  localparam int IMAGE_SIZE_DEF = 600;

  // register indexes of the write port
  typedef enum logic [1:0] {
    REG_CENTER_RE,
    REG_CENTER_IM,
    REG_PIXEL_STEP,
    REG_ITER_LIMIT
  } reg_index_t;

  // one partial-product request to the multiply-accumulate unit
  typedef struct packed {
    logic              issue;
    logic [1:0]        part;
    logic [OPER_W-1:0] a;
    logic [OPER_W-1:0] b;
  } mac_ctl_t;

endpackage

// ----- design/mbe_mac.sv -----
// shared multiply-accumulate unit: one 24x24 partial product per cycle
module mbe_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  mbe_pkg::mac_ctl_t           ctl,
  output logic [mbe_pkg::ACC_W-1:0]   acc
);

  logic [2*mbe_pkg::OPER_W-1:0] prod;
  logic [1:0]                   prod_shift;
  logic                         prod_first;
  logic                         prod_vld;
  logic [mbe_pkg::ACC_W-1:0]    shifted;

  // partial product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod       <= ctl.a * ctl.b;
    prod_shift <= 2'(ctl.part[0]) + 2'(ctl.part[1]);
    prod_first <= (ctl.part == 2'd0);
  end

  // align the partial product by whole slices
  always_comb begin
    case (prod_shift)
      2'd0:    shifted = mbe_pkg::ACC_W'(prod);
      2'd1:    shifted = mbe_pkg::ACC_W'({prod, {mbe_pkg::OPER_W{1'b0}}});
      2'd2:    shifted = mbe_pkg::ACC_W'({prod, {(2*mbe_pkg::OPER_W){1'b0}}});
      default: shifted = '0;
    endcase
  end

  // accumulate, restarting on the first slice of a product
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      acc <= prod_first ? shifted : acc + shifted;
    end
  end

endmodule

// ----- design/mandelbrot_escape_time_pixel_top.sv -----
// top level of the mandelbrot escape-time pixel evaluator
//
// Takes one pixel (pixel_x, pixel_y), maps it to the point c in the complex plane from
// the view center and pixel step registers (signed Q4.44), iterates z = z*z + c from
// zero and returns the escape count together with a gray level (the count scaled by
// 256/limit when the limit is below 256, taken mod 256). All products run through one
// 24x24-bit multiplier that builds each product of two 48-bit operands from four
// partial products; one iteration is three products and two escape tests.
// s_axis_tready is high only while no item is being worked on; a finished result
// waits in the output register, and the next item is taken as soon as the result
// has been loaded there.
module mandelbrot_escape_time_pixel_top #(
  parameter int IMAGE_SIZE = mbe_pkg::IMAGE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] pixel_x, [19:10] pixel_y, rest zero
  // result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] gray_level, [23:8] iteration_count
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int FRAC_BITS = 44;
  localparam int MAG_W     = FRAC_BITS + 1;        // magnitude of a component below 2.0
  localparam int SQ_W      = mbe_pkg::ACC_W - FRAC_BITS;
  localparam int CW        = 60;                   // width of c and z
  localparam int OPND_W    = 2 * mbe_pkg::OPER_W;
  localparam int HALF_W    = OPND_W;               // as wide as a full operand, an operand slice pair

  localparam logic [46:0] STEP_RESET  = 47'd117281240296;
  localparam logic [16:0] LIMIT_RESET = 17'd256;
  localparam logic [16:0] LIMIT_MAX   = 17'h10000;
  localparam logic [2:0]  MUL_LAST    = 3'd4;
  localparam logic [3:0]  DIV_STEPS   = 4'd9;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_STORE = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_SUM   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_HALF,
    OP_CRE,
    OP_CIM,
    OP_RR,
    OP_II,
    OP_RI,
    OP_GRAY
  } op_t;

  // configuration
  logic signed [47:0] center_re;
  logic signed [47:0] center_im;
  logic [46:0]        pixel_step;
  logic [16:0]        iteration_limit;

  // sequencer and datapath registers
  state_t             state;
  op_t                op;
  logic [2:0]         cnt;
  logic [9:0]         px;
  logic [9:0]         py;
  logic signed [CW-1:0] off_re;
  logic signed [CW-1:0] off_im;
  logic signed [CW-1:0] cr;
  logic signed [CW-1:0] ci;
  logic signed [CW-1:0] zr;
  logic signed [CW-1:0] zi;
  logic [MAG_W-1:0]   zr_mag;
  logic [MAG_W-1:0]   zi_mag;
  logic               prod_neg;
  logic [SQ_W-1:0]    r2;
  logic [SQ_W-1:0]    i2;
  logic signed [SQ_W:0] diff;
  logic [15:0]        n;
  logic [8:0]         rem;
  logic [8:0]         quot;
  logic [3:0]         div_cnt;
  logic               out_valid;
  logic [7:0]         gray_out;
  logic [15:0]        count_out;

  // combinational helpers
  logic [16:0]        lim_eff;
  logic [15:0]        lim_m1;
  logic               lim_small;
  logic               div_bit;
  logic [8:0]         div_shift;
  logic [8:0]         div_sub;
  logic               div_ge;
  logic [CW-1:0]      zr_abs;
  logic [CW-1:0]      zi_abs;
  logic               z_esc;
  logic [SQ_W:0]      sq_sum;
  logic [HALF_W-1:0]  ri_pos;
  logic [HALF_W-1:0]  ri_term;
  logic               ri_carry;
  logic signed [CW-1:0] zi_new;
  logic signed [CW-1:0] zr_new;
  logic signed [CW-1:0] center_re_x;
  logic signed [CW-1:0] center_im_x;
  logic signed [CW-1:0] half_val;
  logic [OPND_W-1:0]  opnd_a;
  logic [OPND_W-1:0]  opnd_b;
  logic               res_load;
  mbe_pkg::mac_ctl_t  mac_ctl;
  logic [mbe_pkg::ACC_W-1:0] acc;

  // effective iteration limit
  always_comb begin
    if (iteration_limit == 17'd0) begin
      lim_eff = 17'd1;
    end else if (iteration_limit > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end else begin
      lim_eff = iteration_limit;
    end
    lim_m1    = 16'(lim_eff - 17'd1);
    lim_small = (lim_eff[16:8] == 9'd0);
  end

  // restoring divider step for 256 / limit, one quotient bit a cycle
  always_comb begin
    div_bit   = (div_cnt == DIV_STEPS);
    div_shift = {rem[7:0], div_bit};
    div_ge    = (div_shift >= {1'b0, lim_eff[7:0]});
    div_sub   = div_shift - {1'b0, lim_eff[7:0]};
  end

  // escape test on the components and the squared magnitude
  always_comb begin
    zr_abs = zr[CW-1] ? CW'(-zr) : CW'(zr);
    zi_abs = zi[CW-1] ? CW'(-zi) : CW'(zi);
    z_esc  = (|zr_abs[CW-1:MAG_W]) || (|zi_abs[CW-1:MAG_W]);
    sq_sum = {1'b0, r2} + {1'b0, i2};
  end

  // next z: floor of 2*zr*zi from the magnitude product, then the adds with c
  always_comb begin
    ri_pos   = {1'b0, acc[mbe_pkg::ACC_W-1:FRAC_BITS-1]};
    ri_term  = prod_neg ? ~ri_pos : ri_pos;
    ri_carry = prod_neg && (acc[FRAC_BITS-2:0] == '0);
    zi_new   = ci + {{(CW-HALF_W){ri_term[HALF_W-1]}}, ri_term} + CW'(ri_carry);
    zr_new   = cr + {{(CW-SQ_W-1){diff[SQ_W]}}, diff};
  end

  // view offset terms
  always_comb begin
    center_re_x = {{(CW-48){center_re[47]}}, center_re};
    center_im_x = {{(CW-48){center_im[47]}}, center_im};
    half_val    = {1'b0, acc[CW-1:1]};
  end

  // operands of the current product
  always_comb begin
    case (op)
      OP_HALF: begin
        opnd_a = OPND_W'(pixel_step);
        opnd_b = OPND_W'(IMAGE_SIZE);
      end
      OP_CRE: begin
        opnd_a = OPND_W'(pixel_step);
        opnd_b = OPND_W'(px);
      end
      OP_CIM: begin
        opnd_a = OPND_W'(pixel_step);
        opnd_b = OPND_W'(py);
      end
      OP_RR: begin
        opnd_a = OPND_W'(zr_mag);
        opnd_b = OPND_W'(zr_mag);
      end
      OP_II: begin
        opnd_a = OPND_W'(zi_mag);
        opnd_b = OPND_W'(zi_mag);
      end
      OP_RI: begin
        opnd_a = OPND_W'(zr_mag);
        opnd_b = OPND_W'(zi_mag);
      end
      OP_GRAY: begin
        opnd_a = OPND_W'(n);
        opnd_b = OPND_W'(quot);
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
  end

  // slice selection for the shared multiplier
  always_comb begin
    mac_ctl.issue = (state == ST_MUL) && (cnt != MUL_LAST);
    mac_ctl.part  = cnt[1:0];
    mac_ctl.a     = cnt[1] ? opnd_a[OPND_W-1:mbe_pkg::OPER_W]
                           : opnd_a[mbe_pkg::OPER_W-1:0];
    mac_ctl.b     = cnt[0] ? opnd_b[OPND_W-1:mbe_pkg::OPER_W]
                           : opnd_b[mbe_pkg::OPER_W-1:0];
  end

  mbe_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .acc (acc)
  );

  // finished result moves into the output register
  assign res_load = (state == ST_STORE) && (op == OP_GRAY) && (!out_valid || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_re       <= '0;
      center_im       <= '0;
      pixel_step      <= STEP_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (mbe_pkg::reg_index_t'(cfg_index))
        mbe_pkg::REG_CENTER_RE:  center_re       <= cfg_data;
        mbe_pkg::REG_CENTER_IM:  center_im       <= cfg_data;
        mbe_pkg::REG_PIXEL_STEP: pixel_step      <= cfg_data[46:0];
        mbe_pkg::REG_ITER_LIMIT: iteration_limit <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      // result taken downstream
      if (out_valid && m_axis_tready && !res_load) begin
        out_valid <= 1'b0;
      end

      // quotient runs beside the setup products
      if (div_cnt != 4'd0) begin
        rem     <= div_ge ? div_sub : div_shift;
        quot    <= {quot[7:0], div_ge};
        div_cnt <= div_cnt - 4'd1;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            px    <= s_axis_tdata[9:0];
            py    <= s_axis_tdata[19:10];
            op    <= OP_HALF;
            cnt   <= '0;
            state <= ST_MUL;
            if (lim_small) begin
              div_cnt <= DIV_STEPS;
              rem     <= '0;
              quot    <= '0;
            end else begin
              div_cnt <= '0;
              quot    <= 9'd1;
            end
          end
        end

        ST_MUL: begin
          cnt <= cnt + 3'd1;
          if (cnt == MUL_LAST) begin
            state <= ST_STORE;
          end
        end

        ST_STORE: begin
          cnt <= '0;
          case (op)
            OP_HALF: begin
              off_re <= center_re_x - half_val;
              off_im <= center_im_x - half_val;
              op     <= OP_CRE;
              state  <= ST_MUL;
            end
            OP_CRE: begin
              cr    <= off_re + {1'b0, acc[CW-2:0]};
              op    <= OP_CIM;
              state <= ST_MUL;
            end
            OP_CIM: begin
              ci    <= off_im + {1'b0, acc[CW-2:0]};
              zr    <= '0;
              zi    <= '0;
              n     <= '0;
              state <= ST_CHECK;
            end
            OP_RR: begin
              r2    <= acc[mbe_pkg::ACC_W-1:FRAC_BITS];
              op    <= OP_II;
              state <= ST_MUL;
            end
            OP_II: begin
              i2    <= acc[mbe_pkg::ACC_W-1:FRAC_BITS];
              state <= ST_SUM;
            end
            OP_RI: begin
              zr    <= zr_new;
              zi    <= zi_new;
              n     <= n + 16'd1;
              state <= ST_CHECK;
            end
            OP_GRAY: begin
              // hold the result here until the output register is free
              if (res_load) begin
                gray_out  <= acc[7:0];
                count_out <= n;
                out_valid <= 1'b1;
                state     <= ST_IDLE;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end

        // limit reached or a component at or beyond 2.0
        ST_CHECK: begin
          cnt <= '0;
          state <= ST_MUL;
          if ((n == lim_m1) || z_esc) begin
            op <= OP_GRAY;
          end else begin
            zr_mag   <= zr_abs[MAG_W-1:0];
            zi_mag   <= zi_abs[MAG_W-1:0];
            prod_neg <= zr[CW-1] ^ zi[CW-1];
            op       <= OP_RR;
          end
        end

        // squared magnitude at or beyond 4.0
        ST_SUM: begin
          cnt   <= '0;
          state <= ST_MUL;
          diff  <= {1'b0, r2} - {1'b0, i2};
          op    <= sq_sum[SQ_W] ? OP_GRAY : OP_RI;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // ports
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {count_out, gray_out};

endmodule
